// ===== rtl/msc_pkg.sv =====
package msc_pkg;

   // Range limits of the threshold and hysteresis counts
   localparam logic [15:0] THR_MIN = 16'd16;
   localparam logic [15:0] THR_MAX = 16'd3840;
   localparam logic [15:0] HYS_MIN = 16'd8;
   localparam logic [15:0] HYS_MAX = 16'd1792;

   // Special codes
   localparam logic [6:0] THR_LATCH_CODE = 7'h7F;
   localparam logic [5:0] HYS_ZERO_CODE  = 6'h3F;

   // One count in uT: 5 in the narrow range, 5 * 10 in the wide range
   localparam logic [17:0] UT_PER_LSB_NARROW = 18'd5;
   localparam logic [17:0] UT_PER_LSB_WIDE   = 18'd50;

   // Reciprocals for the constant divides, exact for any 18-bit dividend
   localparam logic [35:0] DIV5_RECIP  = 36'd209716;   // ceil(2^20 / 5)
   localparam logic [36:0] DIV50_RECIP = 37'd335545;   // ceil(2^24 / 50)

   localparam logic [2:0] CSR_WIDE_RANGE_INDEX = 3'd0;

   typedef enum logic {
      KIND_ENCODE = 1'b0,
      KIND_DECODE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [17:0] threshold_in;
      logic [17:0] hysteresis_in;
      logic        polarity_high_in;
      logic [7:0]  threshold_code_in;
      logic [7:0]  hysteresis_code_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  threshold_code_out;
      logic [5:0]  hysteresis_code_out;
      logic [17:0] threshold_out;
      logic [17:0] hysteresis_out;
      logic        polarity_high_out;
   } rsp_word_type;

   function automatic logic [15:0] div_by_5(input logic [17:0] x);
      logic [35:0] p;
      p = 36'(x) * DIV5_RECIP;
      return p[35:20];
   endfunction

   function automatic logic [12:0] div_by_50(input logic [17:0] x);
      logic [36:0] p;
      p = 37'(x) * DIV50_RECIP;
      return p[36:24];
   endfunction

   // Position of the leading one
   function automatic logic [3:0] msb_pos(input logic [11:0] v);
      logic [3:0] pos;
      pos = '0;
      for (int i = 0; i < 12; i++) begin
         if (v[i]) begin
            pos = 4'(i);
         end
      end
      return pos;
   endfunction

   // Counts to uT: times 5, and times 10 again in the wide range
   function automatic logic [17:0] counts_to_ut(input logic [11:0] cnt, input logic wide);
      logic [14:0] x5;
      logic [17:0] x50;
      x5  = (15'(cnt) << 2) + 15'(cnt);
      x50 = (18'(x5) << 3) + (18'(x5) << 1);
      return wide ? x50 : 18'(x5);
   endfunction

endpackage

// ===== rtl/magnetic_switch_threshold_codec.sv =====
// Channel  Direction  Handshake             Word
// req      in         req_valid/req_stall   kind, uT values, codes
// rsp      out        rsp_valid/rsp_stall   codes, uT values, polarity
// csr      in/out     APB psel/penable      wide_range at byte address 0
//
// One word per cycle sustained while rsp_stall is low; a held result stalls the input.
// An accepted word passes through the input register and then the result register,
// with the divide, clamp and normalise logic between them.
// Synchronous reset clears the valid flags and wide_range.
// A stalled result holds; the input register still fills behind it.
module magnetic_switch_threshold_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [17:0] req_threshold_in,
   input  logic [17:0] req_hysteresis_in,
   input  logic        req_polarity_high_in,
   input  logic [7:0]  req_threshold_code_in,
   input  logic [7:0]  req_hysteresis_code_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_threshold_code_out,
   output logic [5:0]  rsp_hysteresis_code_out,
   output logic [17:0] rsp_threshold_out,
   output logic [17:0] rsp_hysteresis_out,
   output logic        rsp_polarity_high_out,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import msc_pkg::*;

   logic         wide_range;
   req_word_type req_word_ff;
   req_word_type req_word_in;
   logic         req_valid_ff;
   logic         req_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         rsp_free;
   logic         req_free;
   logic         move;
   logic [7:0]   enc_thr_code;
   logic [5:0]   enc_hys_code;
   logic [17:0]  dec_thr;
   logic [17:0]  dec_hys;
   logic         dec_pol;

   msc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .wide_range (wide_range)
   );

   msc_encode u_encode (
      .word            (req_word_ff),
      .wide_range      (wide_range),
      .threshold_code  (enc_thr_code),
      .hysteresis_code (enc_hys_code)
   );

   msc_decode u_decode (
      .word          (req_word_ff),
      .wide_range    (wide_range),
      .threshold_ut  (dec_thr),
      .hysteresis_ut (dec_hys),
      .polarity_high (dec_pol)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = req_valid_ff && rsp_free;
   assign req_free  = !req_valid_ff || rsp_free;
   assign req_stall = !req_free;

   always_comb begin
      req_word_in  = req_word_ff;
      req_valid_in = req_valid_ff;
      if (req_free) begin
         req_valid_in = req_valid;
         req_word_in.kind               = kind_type'(req_kind);
         req_word_in.threshold_in       = req_threshold_in;
         req_word_in.hysteresis_in      = req_hysteresis_in;
         req_word_in.polarity_high_in   = req_polarity_high_in;
         req_word_in.threshold_code_in  = req_threshold_code_in;
         req_word_in.hysteresis_code_in = req_hysteresis_code_in;
      end

      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = move;
      end
      if (move) begin
         rsp_word_in = '0;
         unique case (req_word_ff.kind)
            KIND_ENCODE: begin
               rsp_word_in.threshold_code_out  = enc_thr_code;
               rsp_word_in.hysteresis_code_out = enc_hys_code;
            end
            KIND_DECODE: begin
               rsp_word_in.threshold_out     = dec_thr;
               rsp_word_in.hysteresis_out    = dec_hys;
               rsp_word_in.polarity_high_out = dec_pol;
            end
            default: begin
               rsp_word_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_word_ff <= req_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_threshold_code_out  = rsp_word_ff.threshold_code_out;
   assign rsp_hysteresis_code_out = rsp_word_ff.hysteresis_code_out;
   assign rsp_threshold_out       = rsp_word_ff.threshold_out;
   assign rsp_hysteresis_out      = rsp_word_ff.hysteresis_out;
   assign rsp_polarity_high_out   = rsp_word_ff.polarity_high_out;

endmodule

// ===== rtl/msc_csr.sv =====
module msc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        wide_range
);
   import msc_pkg::*;

   logic wide_range_ff;
   logic wide_range_in;
   logic hit;

   // register index is the word address
   assign hit = ({2'b00, paddr[2]} == CSR_WIDE_RANGE_INDEX);

   always_comb begin
      wide_range_in = wide_range_ff;
      if (psel && penable && pwrite && hit) begin
         wide_range_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_range_ff <= 1'b0;
      end else begin
         wide_range_ff <= wide_range_in;
      end
   end

   assign prdata     = hit ? {31'd0, wide_range_ff} : 32'd0;
   assign pready     = 1'b1;
   assign wide_range = wide_range_ff;

endmodule

// ===== rtl/msc_encode.sv =====
module msc_encode (
   input  msc_pkg::req_word_type word,
   input  logic                  wide_range,
   output logic [7:0]            threshold_code,
   output logic [5:0]            hysteresis_code
);
   import msc_pkg::*;

   logic        thr_latch;
   logic [15:0] thr_counts;
   logic [11:0] thr_clamped;
   logic [2:0]  thr_exp;
   logic [11:0] thr_norm;
   logic [17:0] hys_src;
   logic        hys_zero;
   logic [15:0] hys_counts;
   logic [10:0] hys_clamped;
   logic [2:0]  hys_exp;
   logic [11:0] hys_norm;

   always_comb begin
      // below one count means latch mode; a compare avoids waiting on the divide
      thr_latch  = wide_range ? (word.threshold_in < UT_PER_LSB_WIDE)
                              : (word.threshold_in < UT_PER_LSB_NARROW);
      thr_counts = wide_range ? 16'(div_by_50(word.threshold_in))
                              : div_by_5(word.threshold_in);
      if (thr_counts > THR_MAX) begin
         thr_clamped = THR_MAX[11:0];
      end else if (thr_counts < THR_MIN) begin
         thr_clamped = THR_MIN[11:0];
      end else begin
         thr_clamped = thr_counts[11:0];
      end
      thr_exp  = 3'(msb_pos(thr_clamped) - 4'd4);
      thr_norm = thr_clamped >> thr_exp;
      threshold_code = {~word.polarity_high_in,
                        thr_latch ? THR_LATCH_CODE : {thr_exp, thr_norm[3:0]}};

      // latch mode halves the hysteresis
      hys_src    = thr_latch ? (word.hysteresis_in >> 1) : word.hysteresis_in;
      hys_zero   = (hys_src == 18'd0);
      hys_counts = wide_range ? 16'(div_by_50(hys_src)) : div_by_5(hys_src);
      if (hys_counts > HYS_MAX) begin
         hys_clamped = HYS_MAX[10:0];
      end else if (hys_counts < HYS_MIN) begin
         hys_clamped = HYS_MIN[10:0];
      end else begin
         hys_clamped = hys_counts[10:0];
      end
      hys_exp  = 3'(msb_pos({1'b0, hys_clamped}) - 4'd3);
      hys_norm = {1'b0, hys_clamped} >> hys_exp;
      hysteresis_code = hys_zero ? HYS_ZERO_CODE : {hys_exp, hys_norm[2:0]};
   end

endmodule

// ===== rtl/msc_decode.sv =====
module msc_decode (
   input  msc_pkg::req_word_type word,
   input  logic                  wide_range,
   output logic [17:0]           threshold_ut,
   output logic [17:0]           hysteresis_ut,
   output logic                  polarity_high
);
   import msc_pkg::*;

   logic [11:0] thr_raw;
   logic [10:0] hys_raw;
   logic        thr_over;
   logic [11:0] thr_cnt;
   logic [10:0] hys_val;
   logic [11:0] hys_cnt;

   always_comb begin
      // leading one restores the implicit base (16 or 8)
      thr_raw  = 12'({1'b1, word.threshold_code_in[3:0]}) << word.threshold_code_in[6:4];
      hys_raw  = 11'({1'b1, word.hysteresis_code_in[2:0]}) << word.hysteresis_code_in[5:3];
      thr_over = (16'(thr_raw) > THR_MAX);
      thr_cnt  = thr_over ? 12'd0 : thr_raw;
      hys_val  = (16'(hys_raw) > HYS_MAX) ? 11'd0 : hys_raw;
      // an out-of-range threshold decodes as latch, where hysteresis counts double
      hys_cnt  = thr_over ? {hys_val, 1'b0} : {1'b0, hys_val};

      threshold_ut  = counts_to_ut(thr_cnt, wide_range);
      hysteresis_ut = counts_to_ut(hys_cnt, wide_range);
      polarity_high = ~word.threshold_code_in[7];
   end

endmodule

// ===== tb/magnetic_switch_threshold_codec_tb.sv =====
`timescale 1ns / 100ps

module magnetic_switch_threshold_codec_tb;
   import msc_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct {
      kind_type kind;
      int       thr;
      int       hys;
      bit       pol;
      int       tcode;
      int       hcode;
      bit       typed;
      int       x_tcode;
      int       x_hcode;
      int       x_thr;
      int       x_hys;
      bit       x_pol;
   } probe_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [17:0] req_threshold_in = '0;
   logic [17:0] req_hysteresis_in = '0;
   logic        req_polarity_high_in = 1'b0;
   logic [7:0]  req_threshold_code_in = '0;
   logic [7:0]  req_hysteresis_code_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_threshold_code_out;
   logic [5:0]  rsp_hysteresis_code_out;
   logic [17:0] rsp_threshold_out;
   logic [17:0] rsp_hysteresis_out;
   logic        rsp_polarity_high_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   rsp_word_type  due_conversions [$];
   probe_row_type probe_rows [$];
   bit            wide_now = 1'b0;
   bit            quiet = 1'b0;
   int            gap_pct = 0;
   int            stall_pct = 0;
   int            stall_left = 0;
   int            cyc = 0;
   int            dead_cycles = 0;
   int            miss_cnt = 0;
   int            words_sent = 0;
   int            encode_cnt = 0;
   int            results_seen = 0;

   always #10 clock = ~clock;

   magnetic_switch_threshold_codec u_top (.*);

   // Conversion of one word at the given range setting
   function automatic rsp_word_type convert_word(req_word_type w, bit wide);
      int unsigned  t;
      int unsigned  h;
      int unsigned  e;
      rsp_word_type r;
      r = '0;
      if (w.kind == KIND_ENCODE) begin
         t = w.threshold_in / 5;
         if (wide) begin
            t = t / 10;
         end
         h = w.hysteresis_in;
         r.threshold_code_out[7] = ~w.polarity_high_in;
         if (t == 0) begin
            r.threshold_code_out[6:0] = THR_LATCH_CODE;
            h = h >> 1;
         end else begin
            if (t > THR_MAX) begin
               t = THR_MAX;
            end else if (t < THR_MIN) begin
               t = THR_MIN;
            end
            e = 0;
            while (t - THR_MIN > 15) begin
               t = t >> 1;
               e++;
            end
            r.threshold_code_out[6:0] = {3'(e), 4'(t - THR_MIN)};
         end
         if (h == 0) begin
            r.hysteresis_code_out = HYS_ZERO_CODE;
         end else begin
            h = h / 5;
            if (wide) begin
               h = h / 10;
            end
            if (h > HYS_MAX) begin
               h = HYS_MAX;
            end else if (h < HYS_MIN) begin
               h = HYS_MIN;
            end
            e = 0;
            while (h - HYS_MIN > 7) begin
               h = h >> 1;
               e++;
            end
            r.hysteresis_code_out = {3'(e), 3'(h - HYS_MIN)};
         end
      end else begin
         t = (THR_MIN + w.threshold_code_in[3:0]) << w.threshold_code_in[6:4];
         h = (HYS_MIN + w.hysteresis_code_in[2:0]) << w.hysteresis_code_in[5:3];
         if (t > THR_MAX) begin
            t = 0;
         end
         if (h > HYS_MAX) begin
            h = 0;
         end
         if (t == 0) begin
            h = h << 1;
         end
         r.threshold_out = 18'(t * (wide ? UT_PER_LSB_WIDE : UT_PER_LSB_NARROW));
         r.hysteresis_out = 18'(h * (wide ? UT_PER_LSB_WIDE : UT_PER_LSB_NARROW));
         r.polarity_high_out = ~w.threshold_code_in[7];
      end
      return r;
   endfunction

   // uT values spread over the latch boundary, the clamp edges and the full field
   function automatic logic [17:0] random_ut();
      case ($urandom_range(5))
         0: return 18'($urandom_range(0, 60));
         1: return 18'($urandom_range(0, 1000));
         2: return 18'($urandom_range(0, 20000));
         3: return 18'($urandom_range(150000, 262143));
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 10;
         default: return 40;
      endcase
   endfunction

   task automatic note_miss(string what);
      miss_cnt++;
      if (miss_cnt <= 10) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endtask

   task automatic check_field(string name, int unsigned x, int unsigned got);
      if (x != got) begin
         note_miss($sformatf("%s expected 0x%0h got 0x%0h", name, x, got));
      end
   endtask

   task automatic send_word(req_word_type w, rsp_word_type x);
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_threshold_in <= w.threshold_in;
      req_hysteresis_in <= w.hysteresis_in;
      req_polarity_high_in <= w.polarity_high_in;
      req_threshold_code_in <= w.threshold_code_in;
      req_hysteresis_code_in <= w.hysteresis_code_in;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      due_conversions.push_back(x);
      words_sent++;
      if (w.kind == KIND_ENCODE) begin
         encode_cnt++;
      end
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_conversions.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write wide_range, then read it straight back
   task automatic set_range(bit wide);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(CSR_WIDE_RANGE_INDEX << 2);
      pwdata <= 32'(wide);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      wide_now = wide;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      check_field("wide_range readback", wide_now, prdata);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result side: random stall bursts, with the burst rate re-picked by pick_pct as cyc runs
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc % 256 == 0) begin
         stall_pct <= pick_pct();
      end
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_conversions.size() == 0) begin
            note_miss("result word with nothing due");
         end else begin
            x = due_conversions.pop_front();
            results_seen++;
            check_field("threshold_code_out", x.threshold_code_out, rsp_threshold_code_out);
            check_field("hysteresis_code_out", x.hysteresis_code_out,
                        rsp_hysteresis_code_out);
            check_field("threshold_out", x.threshold_out, rsp_threshold_out);
            check_field("hysteresis_out", x.hysteresis_out, rsp_hysteresis_out);
            check_field("polarity_high_out", x.polarity_high_out, rsp_polarity_high_out);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         dead_cycles <= 0;
      end else begin
         dead_cycles <= dead_cycles + 1;
         if (dead_cycles == STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_word_type  w;
      rsp_word_type  x;
      probe_row_type row;
      int            n;

      // kind, thr, hys, pol, tcode, hcode, typed, then the typed result
      probe_rows.push_back('{KIND_ENCODE, 0, 0, 1, 0, 0, 1, 'h7F, 'h3F, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 0, 0, 0, 'hFF, 'hFF, 1, 'hFF, 'h3F, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 4, 1, 1, 0, 0, 1, 'h7F, 'h3F, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 262143, 262143, 1, 'hFF, 'hFF, 1,
                             'h7E, 'h3E, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 80, 40, 1, 0, 0, 1, 'h00, 'h00, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 5, 5, 1, 0, 0, 1, 'h00, 'h00, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 0, 2, 1, 0, 0, 1, 'h7F, 'h00, 0, 0, 0});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'h00, 'h00, 1, 0, 0, 80, 40, 1});
      probe_rows.push_back('{KIND_DECODE, 262143, 262143, 1, 'hFF, 'hFF, 1, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'h7E, 'h3E, 1, 0, 0, 19200, 8960, 1});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'h7F, 'h00, 1, 0, 0, 0, 80, 1});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'h80, 'hC0, 1, 0, 0, 80, 40, 0});
      // the rest go through the predictor
      probe_rows.push_back('{KIND_ENCODE, 1000, 300, 0, 'hFF, 'hFF, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 19200, 8960, 1, 0, 0, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 19205, 8965, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 79, 39, 1, 0, 0, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 3, 262143, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_ENCODE, 131072, 65536, 1, 'h55, 'hAA, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_DECODE, 262143, 0, 1, 'h35, 'h1A, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'h70, 'h38, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'h00, 'h3F, 0, 0, 0, 0, 0, 0});
      probe_rows.push_back('{KIND_DECODE, 0, 0, 0, 'hF0, 'h7F, 0, 0, 0, 0, 0, 0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct = 20;
      for (int k = 0; k < probe_rows.size(); k++) begin
         row = probe_rows[k];
         w.kind = row.kind;
         w.threshold_in = 18'(row.thr);
         w.hysteresis_in = 18'(row.hys);
         w.polarity_high_in = row.pol;
         w.threshold_code_in = 8'(row.tcode);
         w.hysteresis_code_in = 8'(row.hcode);
         if (row.typed) begin
            x.threshold_code_out = 8'(row.x_tcode);
            x.hysteresis_code_out = 6'(row.x_hcode);
            x.threshold_out = 18'(row.x_thr);
            x.hysteresis_out = 18'(row.x_hys);
            x.polarity_high_out = row.x_pol;
         end else begin
            x = convert_word(w, wide_now);
         end
         maybe_gap();
         send_word(w, x);
      end

      // range settings: wide, narrow, wide, then narrow with no idling
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         set_range(ph % 2 == 0);
         quiet = (ph == 3);
         n = quiet ? 150 : 280;
         for (int i = 0; i < n; i++) begin
            if (i % 32 == 0) begin
               gap_pct = pick_pct();
            end
            w.kind = kind_type'($urandom_range(1));
            w.threshold_in = random_ut();
            w.hysteresis_in = random_ut();
            w.polarity_high_in = 1'($urandom_range(1));
            w.threshold_code_in = 8'($urandom);
            w.hysteresis_code_in = 8'($urandom);
            maybe_gap();
            send_word(w, convert_word(w, wide_now));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("%0d words sent (%0d encode, %0d decode) across both ranges, %0d results checked",
               words_sent, encode_cnt, words_sent - encode_cnt, results_seen);
      $display("%0d mismatches", miss_cnt);
      if (miss_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
